FILE: src/rcrt_pkg.sv
package rcrt_pkg;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_EV,
		S_OFF,
		S_LM1,
		S_DEC,
		S_NRD,
		S_NEV,
		S_WPREV,
		S_WCUR,
		S_WNEXT,
		S_WONE,
		S_WREST,
		S_SHRD,
		S_SHWR,
		S_DONE
	} state_t;

	// how a mark reshapes the missing run it lands in
	typedef enum logic [1:0] {
		ED_JOIN,
		ED_HEAD,
		ED_TAIL,
		ED_SPLIT
	} edit_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		logic wr_en;
		logic init;
	} st_ctl_t;

	localparam logic REG_TOTAL = 1'b0;

endpackage

FILE: src/rcrt_alu.sv
module rcrt_alu import rcrt_pkg::*; #(
	parameter int INDEX_BITS = 32,
	localparam int LW = (INDEX_BITS < 32) ? INDEX_BITS : 32
) (
	input  alu_op_t         op,
	input  logic [LW-1:0]   a,
	input  logic [LW-1:0]   b,
	input  logic [LW-1:0]   c,
	output logic [LW-1:0]   y,
	output logic            lt
);

	always_comb begin
		unique case (op)
			ALU_ADD: y = a + b;
			ALU_SUB: y = a - b;
			default: y = a + b;
		endcase
	end

	assign lt = c < y;

endmodule

FILE: src/rcrt_store.sv
module rcrt_store import rcrt_pkg::*; #(
	parameter int MAX_RUNS   = 64,
	parameter int INDEX_BITS = 32,
	localparam int LW = (INDEX_BITS < 32) ? INDEX_BITS : 32,
	localparam int IW = $clog2(MAX_RUNS)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  st_ctl_t         ctl,
	input  logic [IW-1:0]   wr_addr,
	input  logic [LW-1:0]   wr_data,
	input  logic [IW-1:0]   rd_addr,
	output logic [LW-1:0]   rd_data,
	output logic [LW-1:0]   head
);

	// entry zero lives in a register so it resets and is always visible
	logic [LW-1:0] mem [MAX_RUNS];
	logic [LW-1:0] mem_rd_s1;
	logic          rd_zero_s1;
	logic [LW-1:0] r0_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en && (wr_addr != '0)) begin
			mem[wr_addr] <= wr_data;
		end
		mem_rd_s1  <= mem[rd_addr];
		rd_zero_s1 <= (rd_addr == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r0_q <= '0;
		end else if (ctl.init) begin
			r0_q <= '0;
		end else if (ctl.wr_en && (wr_addr == '0)) begin
			r0_q <= wr_data;
		end
	end

	assign rd_data = rd_zero_s1 ? r0_q : mem_rd_s1;
	assign head    = r0_q;

endmodule

FILE: src/rcrt_ctrl.sv
module rcrt_ctrl import rcrt_pkg::*; #(
	parameter int MAX_RUNS   = 64,
	parameter int INDEX_BITS = 32,
	localparam int LW = (INDEX_BITS < 32) ? INDEX_BITS : 32,
	localparam int CW = $clog2(MAX_RUNS + 1),
	localparam int IW = $clog2(MAX_RUNS)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            mode,
	input  logic [31:0]     index,
	input  logic            cfg_we,
	input  logic [LW-1:0]   cfg_total,
	output logic            busy,
	output logic            done,
	output logic            is_received,
	output logic            all_received,
	output logic            overflow,
	output alu_op_t         alu_op,
	output logic [LW-1:0]   alu_a,
	output logic [LW-1:0]   alu_b,
	output logic [LW-1:0]   alu_c,
	input  logic [LW-1:0]   alu_y,
	input  logic            alu_lt,
	output st_ctl_t         st_ctl,
	output logic [IW-1:0]   st_wr_addr,
	output logic [LW-1:0]   st_wr_data,
	output logic [IW-1:0]   st_rd_addr,
	input  logic [LW-1:0]   st_rd_data
);

	state_t        state_q, state_d;
	edit_t         edit_q, edit_d;
	logic [CW-1:0] cnt_q, cnt_new_q, cnt_new_d;
	logic [CW-1:0] ptr_q, j_q;
	logic [LW-1:0] idx_q, pos_q, len_q, prev_q, off_q, lm1_q, acc_q;
	logic          mode_q, nxt_q, rcv_q, ovf_q, ovf_d;
	logic [CW-1:0] ptr_inc, ptr_dec, ptr_inc2, j_inc, wr_addr_c;
	logic          last_run, join_nxt;

	assign ptr_inc  = ptr_q + CW'(1);
	assign ptr_dec  = ptr_q - CW'(1);
	assign ptr_inc2 = ptr_q + CW'(2);
	assign j_inc    = j_q + CW'(1);
	assign last_run = (ptr_inc == cnt_q);
	assign join_nxt = (edit_q == ED_JOIN) && nxt_q;

	// classify the mark once offset and length-1 are known
	always_comb begin
		if (off_q == '0) begin
			edit_d = (lm1_q == '0) ? ED_JOIN : ED_HEAD;
		end else if (off_q == lm1_q) begin
			edit_d = ED_TAIL;
		end else begin
			edit_d = ED_SPLIT;
		end
		ovf_d = ((edit_d == ED_TAIL) && last_run && (cnt_q == CW'(MAX_RUNS))) ||
			((edit_d == ED_SPLIT) && (cnt_q > CW'(MAX_RUNS - 2)));
		unique case (edit_d)
			ED_JOIN:  cnt_new_d = last_run ? (cnt_q - CW'(1)) : (cnt_q - CW'(2));
			ED_HEAD:  cnt_new_d = cnt_q;
			ED_TAIL:  cnt_new_d = last_run ? (cnt_q + CW'(1)) : cnt_q;
			ED_SPLIT: cnt_new_d = cnt_q + CW'(2);
			default:  cnt_new_d = cnt_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		alu_op     = ALU_ADD;
		alu_a      = pos_q;
		alu_b      = st_rd_data;
		st_ctl     = '0;
		wr_addr_c  = ptr_q;
		st_wr_data = st_rd_data;
		st_rd_addr = ptr_q[IW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (cfg_we) begin
					st_ctl.wr_en = 1'b1;
					st_ctl.init  = 1'b1;
					wr_addr_c    = CW'(1);
					st_wr_data   = cfg_total;
				end
				if (start) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				state_d = S_EV;
			end
			S_EV: begin
				if (alu_lt) begin
					state_d = (mode_q && ptr_q[0]) ? S_OFF : S_DONE;
				end else begin
					state_d = last_run ? S_DONE : S_RD;
				end
			end
			S_OFF: begin
				alu_op  = ALU_SUB;
				alu_a   = idx_q;
				alu_b   = pos_q;
				state_d = S_LM1;
			end
			S_LM1: begin
				alu_op  = ALU_SUB;
				alu_a   = len_q;
				alu_b   = LW'(1);
				state_d = S_DEC;
			end
			S_DEC: begin
				if (ovf_d) begin
					state_d = S_DONE;
				end else begin
					unique case (edit_d)
						ED_JOIN:  state_d = last_run ? S_WPREV : S_NRD;
						ED_HEAD:  state_d = S_WPREV;
						ED_TAIL:  state_d = S_WCUR;
						ED_SPLIT: state_d = last_run ? S_WCUR : S_SHRD;
						default:  state_d = S_DONE;
					endcase
				end
			end
			S_NRD: begin
				st_rd_addr = ptr_inc[IW-1:0];
				state_d    = S_NEV;
			end
			S_NEV: begin
				alu_a   = st_rd_data;
				alu_b   = (edit_q == ED_JOIN) ? prev_q : LW'(1);
				state_d = (edit_q == ED_JOIN) ? S_WPREV : S_WNEXT;
			end
			S_WPREV: begin
				alu_a        = join_nxt ? acc_q : prev_q;
				alu_b        = LW'(1);
				st_ctl.wr_en = 1'b1;
				wr_addr_c    = ptr_dec;
				st_wr_data   = alu_y;
				if (edit_q == ED_HEAD) begin
					state_d = S_WCUR;
				end else if (join_nxt && (ptr_inc2 != cnt_q)) begin
					state_d = S_SHRD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_WCUR: begin
				st_ctl.wr_en = 1'b1;
				st_wr_data   = (edit_q == ED_SPLIT) ? off_q : lm1_q;
				unique case (edit_q)
					ED_TAIL:  state_d = nxt_q ? S_NRD : S_WONE;
					ED_SPLIT: state_d = S_WONE;
					default:  state_d = S_DONE;
				endcase
			end
			S_WNEXT: begin
				st_ctl.wr_en = 1'b1;
				wr_addr_c    = ptr_inc;
				st_wr_data   = acc_q;
				state_d      = S_DONE;
			end
			S_WONE: begin
				st_ctl.wr_en = 1'b1;
				wr_addr_c    = ptr_inc;
				st_wr_data   = LW'(1);
				state_d      = (edit_q == ED_SPLIT) ? S_WREST : S_DONE;
			end
			S_WREST: begin
				alu_op       = ALU_SUB;
				alu_a        = lm1_q;
				alu_b        = off_q;
				st_ctl.wr_en = 1'b1;
				wr_addr_c    = ptr_inc2;
				st_wr_data   = alu_y;
				state_d      = S_DONE;
			end
			S_SHRD: begin
				st_rd_addr = j_q[IW-1:0];
				state_d    = S_SHWR;
			end
			S_SHWR: begin
				// joins pull later runs down by two, splits push them up by two
				st_ctl.wr_en = 1'b1;
				st_wr_data   = st_rd_data;
				if (edit_q == ED_JOIN) begin
					wr_addr_c = j_q - CW'(2);
					state_d   = (j_inc == cnt_q) ? S_DONE : S_SHRD;
				end else begin
					wr_addr_c = j_q + CW'(2);
					state_d   = (j_q == ptr_inc) ? S_WCUR : S_SHRD;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign st_wr_addr = wr_addr_c[IW-1:0];
	assign alu_c      = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CW'(1);
		end else if ((state_q == S_IDLE) && cfg_we) begin
			cnt_q <= CW'(2);
		end else if ((state_d == S_DONE) && (state_q != S_EV) && (state_q != S_DEC) &&
			(state_q != S_DONE)) begin
			cnt_q <= cnt_new_q;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				idx_q  <= index[LW-1:0];
				mode_q <= mode;
				ptr_q  <= '0;
				pos_q  <= '0;
				rcv_q  <= 1'b0;
				ovf_q  <= 1'b0;
			end
			S_EV: begin
				if (alu_lt) begin
					rcv_q <= !mode_q && !ptr_q[0];
					len_q <= st_rd_data;
				end else begin
					pos_q  <= alu_y;
					prev_q <= st_rd_data;
					ptr_q  <= ptr_inc;
				end
			end
			S_OFF: off_q <= alu_y;
			S_LM1: lm1_q <= alu_y;
			S_DEC: begin
				edit_q    <= edit_d;
				nxt_q     <= !last_run;
				ovf_q     <= ovf_d;
				cnt_new_q <= cnt_new_d;
				j_q       <= cnt_q - CW'(1);
			end
			S_NEV: acc_q <= alu_y;
			S_WPREV: begin
				if (join_nxt) begin
					j_q <= ptr_inc2;
				end
			end
			S_SHWR: j_q <= (edit_q == ED_JOIN) ? j_inc : (j_q - CW'(1));
			default: begin
			end
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = (state_q == S_DONE);
	assign is_received  = rcv_q;
	assign overflow     = ovf_q;
	assign all_received = (cnt_q == CW'(1));

endmodule

FILE: src/received_chunk_run_tracker.sv
// Tracks received chunks as alternating received/missing run lengths in a run
// memory, walked by one shared adder under a small sequencer. Pulse start with
// busy low; the result appears for exactly one cycle with done high and cannot
// be stalled, so sample it then. A query or mark walks the runs, each run visited
// taking a memory read, then an add and compare. A mark then computes its offset
// and length-1, classifies the mark and writes the changed runs, plus a read and
// a write per run moved when a split inserts or a join removes entries, before
// the result. Runs walked and runs moved never add up to more than run_count, and
// the next start is taken in the cycle after done. Writing total_chunks (APB,
// address 0) restarts tracking and must be done while idle.
module received_chunk_run_tracker import rcrt_pkg::*; #(
	parameter int MAX_RUNS   = 64,
	parameter int INDEX_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [31:0] index,
	output logic        done,
	output logic        is_received,
	output logic [31:0] first_missing,
	output logic        all_received,
	output logic        overflow,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int LW = (INDEX_BITS < 32) ? INDEX_BITS : 32;
	localparam int IW = $clog2(MAX_RUNS);

	logic [LW-1:0] total_q;
	logic          cfg_we;
	logic          reg_sel;

	alu_op_t       alu_op;
	logic [LW-1:0] alu_a, alu_b, alu_c, alu_y;
	logic          alu_lt;
	st_ctl_t       st_ctl;
	logic [IW-1:0] st_wr_addr, st_rd_addr;
	logic [LW-1:0] st_wr_data, st_rd_data, head;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_TOTAL);
	assign cfg_we  = psel && penable && pwrite && reg_sel;
	assign prdata  = reg_sel ? 32'(total_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cfg_we) begin
			total_q <= pwdata[LW-1:0];
		end
	end

	rcrt_ctrl #(
		.MAX_RUNS   (MAX_RUNS),
		.INDEX_BITS (INDEX_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.mode         (mode),
		.index        (index),
		.cfg_we       (cfg_we),
		.cfg_total    (pwdata[LW-1:0]),
		.busy         (busy),
		.done         (done),
		.is_received  (is_received),
		.all_received (all_received),
		.overflow     (overflow),
		.alu_op       (alu_op),
		.alu_a        (alu_a),
		.alu_b        (alu_b),
		.alu_c        (alu_c),
		.alu_y        (alu_y),
		.alu_lt       (alu_lt),
		.st_ctl       (st_ctl),
		.st_wr_addr   (st_wr_addr),
		.st_wr_data   (st_wr_data),
		.st_rd_addr   (st_rd_addr),
		.st_rd_data   (st_rd_data)
	);

	rcrt_alu #(
		.INDEX_BITS (INDEX_BITS)
	) u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.c  (alu_c),
		.y  (alu_y),
		.lt (alu_lt)
	);

	rcrt_store #(
		.MAX_RUNS   (MAX_RUNS),
		.INDEX_BITS (INDEX_BITS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (st_ctl),
		.wr_addr (st_wr_addr),
		.wr_data (st_wr_data),
		.rd_addr (st_rd_addr),
		.rd_data (st_rd_data),
		.head    (head)
	);

	assign first_missing = 32'(head);

endmodule
